>>> hdl/strm_pkg.sv
// Shared constants, types and helpers of the sparse-table range-minimum block.
`default_nettype none

package strm_pkg;

  localparam int unsigned SIZE_DEF   = 1024;
  localparam int unsigned LEVELS_DEF = 11;

  localparam int unsigned VALUE_W = 16;
  localparam int unsigned LEFT_W  = 10;
  localparam int unsigned RIGHT_W = 11;
  localparam int unsigned LOG_W   = 4;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef logic [VALUE_W-1:0] value_t;

  // Position of the highest set bit; zero input gives zero.
  function automatic logic [LOG_W-1:0] floor_log2(input logic [RIGHT_W-1:0] x);
    logic [LOG_W-1:0] k;
    k = '0;
    for (int i = 0; i < RIGHT_W; i++) begin
      if (x[i]) begin
        k = LOG_W'(i);
      end
    end
    return k;
  endfunction

  function automatic value_t min16(input value_t a, input value_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

`default_nettype wire

>>> hdl/strm_if.sv
// Valid/ready channel interfaces for query/load items and results.
`default_nettype none

interface strm_in_if import strm_pkg::*;;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [VALUE_W-1:0] value;
  logic               last;
  logic [LEFT_W-1:0]  left;
  logic [RIGHT_W-1:0] right;

  modport source (output valid, cmd, value, last, left, right, input ready);
  modport sink   (input valid, cmd, value, last, left, right, output ready);
endinterface

interface strm_out_if import strm_pkg::*;;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] min_value;
  logic               bad_query;

  modport source (output valid, min_value, bad_query, input ready);
  modport sink   (input valid, min_value, bad_query, output ready);
endinterface

`default_nettype wire

>>> hdl/strm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module strm_ram #(
  parameter int unsigned W = 16,
  parameter int unsigned D = 1024,
  localparam int unsigned AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/sparse_table_range_minimum_core.sv
// Sparse-table range-minimum engine: loads an array, builds the doubling table, answers queries.
//
// Usage:
//   in_i  carries load and query items; a transfer happens when valid and ready are high.
//         cmd=0 appends value to the array (dropped once SIZE values are held); last=1
//         closes the array and starts the table build. A load after a build starts a
//         new array. cmd=1 asks for the minimum over left..right-1.
//   out_o carries one result per query (min_value, bad_query), none per load.
// Sequence:
//   load:  in_i.ready stays high after a load without last; last=1 starts the build.
//   query: two reads through the one RAM read port (ST_Q_RDA, ST_Q_RDB), then the
//          compare in ST_DONE into the output register; a bad query (table not built,
//          empty range, right past the count) skips the reads and returns 0 with bad_query set.
//   build: after the last load, every level k+1 entry takes a read, a read and a
//          write-back (ST_B_CHK, ST_B_RDB, ST_B_WR), and each level ends with a check.
//          in_i.ready stays low during the build.
// Reset: count and built flag clear, no result pending. The table RAM has no reset.
// Stall: a result waiting on out_o does not block the next transfer on in_i; a
//   following query parks its finished result until the output register frees up.
// Hazards: the sequencer does one RAM access pair at a time, so no forwarding is needed.
`default_nettype none

module sparse_table_range_minimum_core import strm_pkg::*; #(
  parameter int unsigned SIZE   = SIZE_DEF,
  parameter int unsigned LEVELS = LEVELS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  strm_in_if.sink       in_i,
  strm_out_if.source    out_o
);

  localparam int unsigned DEPTH = LEVELS * SIZE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(SIZE + 1);   // element count
  localparam int unsigned IW    = $clog2(SIZE);       // index within a level
  localparam int unsigned LW    = $clog2(LEVELS);     // level number
  localparam int unsigned XW    = ((CW > LEVELS) ? CW : LEVELS) + 1;  // build bound compare
  localparam int unsigned EW    = (CW > RIGHT_W) ? CW : RIGHT_W;      // query bound compare

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_Q_RDA = 7'b0000010,   // issue read of left window
    ST_Q_RDB = 7'b0000100,   // grab left, issue read of right window
    ST_DONE  = 7'b0001000,   // result waits for the output register
    ST_B_CHK = 7'b0010000,   // bound check, issue read of entry j
    ST_B_RDB = 7'b0100000,   // grab entry j, issue read of entry j+half
    ST_B_WR  = 7'b1000000    // write min into next level
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic                built_q, built_d;
  logic [LW-1:0]       level_q, level_d;
  logic [IW-1:0]       j_q, j_d;
  logic [AW-1:0]       base_q, base_d;
  logic [RIGHT_W-1:0]  idx_a_q, idx_a_d;
  logic [RIGHT_W-1:0]  idx_b_q, idx_b_d;
  value_t              a_q, a_d;
  logic                bad_q, bad_d;
  logic                out_valid_q, out_valid_d;
  value_t              out_min_q, out_min_d;
  logic                out_bad_q, out_bad_d;

  // RAM port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  value_t        ram_wdata, ram_rdata;

  strm_ram #(
    .W (VALUE_W),
    .D (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic               in_xfer;
  logic [CW-1:0]      load_idx;
  logic [RIGHT_W-1:0] q_diff;
  logic [LOG_W-1:0]   q_log;
  logic [LW-1:0]      q_level;
  logic [RIGHT_W-1:0] q_span;
  logic               q_bad;
  logic [XW-1:0]      b_half, b_twohalf;
  logic               b_fit;
  logic               b_top;
  logic               out_free;

  assign in_i.ready      = (state_q == ST_IDLE);
  assign in_xfer         = in_i.valid && in_i.ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.min_value = out_min_q;
  assign out_o.bad_query = out_bad_q;
  assign out_free        = !out_valid_q || out_o.ready;

  // Load index: a load after a build restarts the array.
  assign load_idx = built_q ? '0 : count_q;

  // Query decode: level is floor(log2(right-left)), clamped to the top level.
  assign q_diff  = in_i.right - RIGHT_W'(in_i.left);
  assign q_log   = floor_log2(q_diff);
  assign q_level = (int'(q_log) > LEVELS - 1) ? LW'(LEVELS - 1) : LW'(q_log);
  assign q_span  = RIGHT_W'(1) << q_level;
  assign q_bad   = !built_q || (in_i.right <= RIGHT_W'(in_i.left)) ||
                   (EW'(in_i.right) > EW'(count_q));

  // Build: entry j of level+1 exists while j + 2^(level+1) <= count.
  assign b_half    = XW'(1) << level_q;
  assign b_twohalf = XW'(2) << level_q;
  assign b_fit     = (XW'(j_q) + b_twohalf) <= XW'(count_q);
  assign b_top     = (level_q == LW'(LEVELS - 1));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    built_d     = built_q;
    level_d     = level_q;
    j_d         = j_q;
    base_d      = base_q;
    idx_a_d     = idx_a_q;
    idx_b_d     = idx_b_q;
    a_d         = a_q;
    bad_d       = bad_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_min_d   = out_min_q;
    out_bad_d   = out_bad_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = in_i.value;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_i.cmd == CMD_QUERY) begin
            bad_d   = q_bad;
            idx_a_d = RIGHT_W'(in_i.left);
            idx_b_d = in_i.right - q_span;
            base_d  = AW'(q_level * SIZE);
            state_d = q_bad ? ST_DONE : ST_Q_RDA;
          end else begin
            built_d = 1'b0;
            count_d = load_idx;
            if (load_idx < CW'(SIZE)) begin
              ram_we    = 1'b1;
              ram_waddr = AW'(load_idx);
              ram_wdata = in_i.value;
              count_d   = load_idx + CW'(1);
            end
            if (in_i.last) begin
              level_d = '0;
              j_d     = '0;
              base_d  = '0;
              state_d = ST_B_CHK;
            end
          end
        end
      end

      ST_Q_RDA: begin
        ram_re    = 1'b1;
        ram_raddr = base_q + AW'(idx_a_q);
        state_d   = ST_Q_RDB;
      end

      ST_Q_RDB: begin
        a_d       = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = base_q + AW'(idx_b_q);
        state_d   = ST_DONE;
      end

      ST_DONE: begin
        // RAM read data holds while no read is issued.
        if (out_free) begin
          out_valid_d = 1'b1;
          out_min_d   = bad_q ? '0 : min16(a_q, ram_rdata);
          out_bad_d   = bad_q;
          state_d     = ST_IDLE;
        end
      end

      ST_B_CHK: begin
        if (b_top || !b_fit) begin
          // A level with no entries means none above it either.
          if (b_top || (j_q == '0)) begin
            built_d = 1'b1;
            state_d = ST_IDLE;
          end else begin
            level_d = level_q + LW'(1);
            base_d  = base_q + AW'(SIZE);
            j_d     = '0;
          end
        end else begin
          ram_re    = 1'b1;
          ram_raddr = base_q + AW'(j_q);
          state_d   = ST_B_RDB;
        end
      end

      ST_B_RDB: begin
        a_d       = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = base_q + AW'(j_q) + AW'(b_half);
        state_d   = ST_B_WR;
      end

      ST_B_WR: begin
        ram_we    = 1'b1;
        ram_waddr = base_q + AW'(SIZE) + AW'(j_q);
        ram_wdata = min16(a_q, ram_rdata);
        j_d       = j_q + IW'(1);
        state_d   = ST_B_CHK;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      built_q     <= 1'b0;
      out_valid_q <= 1'b0;
      level_q     <= '0;
      j_q         <= '0;
      base_q      <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      built_q     <= built_d;
      out_valid_q <= out_valid_d;
      level_q     <= level_d;
      j_q         <= j_d;
      base_q      <= base_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_a_q   <= idx_a_d;
    idx_b_q   <= idx_b_d;
    a_q       <= a_d;
    bad_q     <= bad_d;
    out_min_q <= out_min_d;
    out_bad_q <= out_bad_d;
  end

endmodule

`default_nettype wire

>>> hdl/strm_checker.sv
// Port-level assertions for the range-minimum core, bound to the top level.
`default_nettype none

module strm_checker import strm_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               in_cmd_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [VALUE_W-1:0] out_min_value_i,
  input logic               out_bad_query_i
);

  logic       q_acc, o_xfer;
  logic [1:0] pend_q, pend_d;

  assign q_acc  = in_valid_i && in_ready_i && (in_cmd_i == CMD_QUERY);
  assign o_xfer = out_valid_i && out_ready_i;
  assign pend_d = pend_q + {1'b0, q_acc} - {1'b0, o_xfer};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // No result without a query that asked for it.
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_xfer |-> (pend_q != 2'd0))
    else $error("result transfer without pending query");

  // At most one result parked inside plus one in the output register.
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("too many queries in flight");

  // Error results carry zero.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_bad_query_i) |-> (out_min_value_i == '0))
    else $error("bad query with nonzero value");

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_min_value_i) && $stable(out_bad_query_i)))
    else $error("stalled result changed");

endmodule

bind sparse_table_range_minimum_core strm_checker u_strm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_cmd_i        (in_i.cmd),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_min_value_i (out_o.min_value),
  .out_bad_query_i (out_o.bad_query)
);

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the sparse-table range-minimum core.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import strm_pkg::*;

  localparam int unsigned TB_SIZE       = SIZE_DEF;
  localparam int unsigned TB_LEVELS     = LEVELS_DEF;
  // The limit covers a few dozen table builds plus roughly 1700 transfers
  // under heavy stalls, several times over.
  localparam int unsigned CYCLE_LIMIT   = 4_000_000;
  localparam int unsigned SETTLE_CYCLES = 20;

  typedef struct packed {
    value_t min_value;
    logic   bad_query;
  } range_result_t;

  logic clk_i;
  logic rst_ni;

  strm_in_if  in_if ();
  strm_out_if out_if ();

  sparse_table_range_minimum_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Shadow copy of the table, count and built flag, advanced on every accepted
  // input transfer.
  value_t        shadow_levels [TB_LEVELS][TB_SIZE];
  int unsigned   shadow_count;
  bit            shadow_built;
  range_result_t pending_minima[$];

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned items_sent;
  int unsigned error_count;
  int unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run-away guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results outstanding",
               cycle_count, pending_minima.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    $display("MISMATCH cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned span_log2(input int unsigned x);
    int unsigned k;
    k = 0;
    while (x > 1) begin
      x = x >> 1;
      k++;
    end
    return k;
  endfunction

  // Level k+1 entry j covers level-k entries j and j + 2^k.
  function automatic void rebuild_levels();
    int unsigned half;
    for (int unsigned k = 0; k + 1 < TB_LEVELS; k++) begin
      half = 1 << k;
      for (int unsigned j = 0; j + 2 * half <= shadow_count; j++) begin
        shadow_levels[k+1][j] = (shadow_levels[k][j] < shadow_levels[k][j+half]) ?
                                shadow_levels[k][j] : shadow_levels[k][j+half];
      end
    end
    shadow_built = 1'b1;
  endfunction

  function automatic void predict_transfer(input cmd_e cmd, input value_t value,
                                           input logic last,
                                           input logic [LEFT_W-1:0] left,
                                           input logic [RIGHT_W-1:0] right);
    range_result_t res;
    int unsigned   k;
    int unsigned   span;
    value_t        a;
    value_t        b;
    if (cmd == CMD_LOAD) begin
      // A load after a build starts a fresh array.
      if (shadow_built) begin
        shadow_count = 0;
        shadow_built = 1'b0;
      end
      if (shadow_count < TB_SIZE) begin
        shadow_levels[0][shadow_count] = value;
        shadow_count++;
      end
      if (last) rebuild_levels();
      return;
    end
    if (!shadow_built || right <= left || right > shadow_count) begin
      res.min_value = '0;
      res.bad_query = 1'b1;
    end else begin
      k = span_log2(int'(right) - int'(left));
      if (k > TB_LEVELS - 1) k = TB_LEVELS - 1;
      span = 1 << k;
      a = shadow_levels[k][left];
      b = shadow_levels[k][int'(right) - span];
      res.min_value = (a < b) ? a : b;
      res.bad_query = 1'b0;
    end
    pending_minima.push_back(res);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls, compare each transfer with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    range_result_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (pending_minima.size() == 0) begin
          flag_mismatch($sformatf("result min=%0h bad=%0b with no query outstanding",
                                  out_if.min_value, out_if.bad_query));
        end else begin
          want = pending_minima.pop_front();
          if (out_if.min_value !== want.min_value)
            flag_mismatch($sformatf("min_value %0h, expected %0h",
                                    out_if.min_value, want.min_value));
          if (out_if.bad_query !== want.bad_query)
            flag_mismatch($sformatf("bad_query %0b, expected %0b",
                                    out_if.bad_query, want.bad_query));
        end
      end
      out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Entered and left at a rising edge; valid stays high after the transfer so
  // back-to-back items need no extra assignment in the same step.
  task automatic send_item(input cmd_e cmd, input value_t value, input logic last,
                           input logic [LEFT_W-1:0] left,
                           input logic [RIGHT_W-1:0] right);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.cmd   <= cmd;
    in_if.value <= value;
    in_if.last  <= last;
    in_if.left  <= left;
    in_if.right <= right;
    do @(posedge clk_i); while (!in_if.ready);
    predict_transfer(cmd, value, last, left, right);
    items_sent++;
  endtask

  // Loads carry junk in left/right, queries junk in value/last: both are ignored.
  task automatic send_load(input value_t value, input logic last);
    send_item(CMD_LOAD, value, last, LEFT_W'($urandom), RIGHT_W'($urandom));
  endtask

  task automatic send_query(input int unsigned left, input int unsigned right);
    send_item(CMD_QUERY, value_t'($urandom), 1'($urandom), LEFT_W'(left),
              RIGHT_W'(right));
  endtask

  task automatic send_junk_query();
    send_query($urandom_range(TB_SIZE - 1), $urandom_range(TB_SIZE));
  endtask

  // Well-formed range over the current array once built, else a junk query; short spans
  // are favored so the low levels get as much use as the wide ones.
  task automatic send_valid_query();
    int unsigned lo;
    int unsigned hi;
    if (!shadow_built) begin
      send_junk_query();
    end else begin
      lo = $urandom_range(shadow_count - 1);
      if ($urandom_range(9) < 3) begin
        hi = lo + $urandom_range(1, 4);
        if (hi > shadow_count) hi = shadow_count;
      end else begin
        hi = $urandom_range(shadow_count, lo + 1);
      end
      send_query(lo, hi);
    end
  endtask

  // Mix of full-range values and values crowded at both ends.
  function automatic value_t pick_value();
    case ($urandom_range(3))
      0:       return value_t'($urandom_range(15));
      1:       return 16'hFFFF - value_t'($urandom_range(15));
      default: return value_t'($urandom);
    endcase
  endfunction

  // Sender holds off until every outstanding result has come back.
  task automatic hold_until_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_minima.size() != 0);
  endtask

  task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Nothing built yet: every query is rejected, including the top left index and an empty range.
  task automatic test_unbuilt_queries();
    send_query(0, 1);
    send_query(TB_SIZE - 1, TB_SIZE);
    send_query(0, 0);
  endtask

  // One-element array at the top value; empty, reversed and past-the-end ranges.
  task automatic test_single_element();
    send_item(CMD_LOAD, 16'hFFFF, 1'b1, LEFT_W'(TB_SIZE - 1), RIGHT_W'(TB_SIZE));
    send_query(0, 1);
    send_query(0, 2);
    send_query(1, 1);
    send_query(1, 0);
  endtask

  // A load after a build restarts the array and clears the built flag.
  task automatic test_restart_after_build();
    send_load(16'h0000, 1'b0);
    send_query(0, 1);
    send_load(16'hFFFF, 1'b1);
    send_query(0, 2);
    send_query(1, 2);
    send_query(0, 1);
    send_query(0, 3);
  endtask

  // Five values reach level 2; the two windows overlap.
  task automatic test_five_element_levels();
    send_load(16'd7, 1'b0);
    send_load(16'd3, 1'b0);
    send_load(16'd9, 1'b0);
    send_load(16'h8000, 1'b0);
    send_load(16'd1, 1'b1);
    send_query(0, 5);
    send_query(1, 4);
    hold_until_drained();
  endtask

  // Random arrays, mostly small, each followed by a burst of queries. Some
  // sequences leave out the closing flag so the next one appends, and stray
  // queries land in the middle of loading.
  task automatic run_random_traffic(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned len;
    int unsigned n_queries;
    bit          no_close;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(200, 49) : $urandom_range(48, 1);
      no_close = ($urandom_range(9) == 0);
      for (int unsigned i = 0; i < len; i++) begin
        if ($urandom_range(19) == 0) send_junk_query();
        send_load(pick_value(), (i == len - 1) && !no_close);
      end
      n_queries = $urandom_range(16, 3);
      for (int unsigned q = 0; q < n_queries; q++) begin
        if ($urandom_range(6) == 0) send_junk_query();
        else send_valid_query();
      end
      if ($urandom_range(15) == 0) hold_until_drained();
    end
  endtask

  // Full array, then dropped loads with the closing flag on a dropped one;
  // queries reach the top level and the upper index bits.
  task automatic test_capacity_overflow();
    for (int unsigned i = 0; i < TB_SIZE; i++) send_load(pick_value(), 1'b0);
    send_load(16'h0000, 1'b0);
    send_load(16'h0000, 1'b0);
    send_load(16'h0000, 1'b1);
    send_query(0, TB_SIZE);
    send_query(TB_SIZE - 1, TB_SIZE);
    send_query(0, TB_SIZE - 1);
    send_query(TB_SIZE / 2, TB_SIZE);
    send_query(1, TB_SIZE);
    for (int unsigned q = 0; q < 60; q++) begin
      if ($urandom_range(7) == 0) send_junk_query();
      else send_valid_query();
    end
  endtask

  initial begin
    shadow_count = 0;
    shadow_built = 1'b0;
    items_sent   = 0;
    set_idling(0, 0);
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.cmd    <= CMD_LOAD;
    in_if.value  <= '0;
    in_if.last   <= 1'b0;
    in_if.left   <= '0;
    in_if.right  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(10, 61);
    test_unbuilt_queries();
    test_single_element();
    test_restart_after_build();
    test_five_element_levels();
    run_random_traffic(200);
    hold_until_drained();

    set_idling(61, 10);
    run_random_traffic(200);
    hold_until_drained();

    set_idling(0, 0);
    run_random_traffic(180);
    test_capacity_overflow();

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
